/* sv/ets_pkg.sv */
// ets_pkg: shared constants, command codes and controller/datapath structs
// for the exhaustive tour search block
// no dependencies
package ets_pkg;

  localparam int MAX_CITIES_DEF   = 8;
  localparam int DIST_BITS_DEF    = 16;
  localparam int CITY_W           = 4;
  localparam int DIST_W           = 16;
  localparam int LEN_OUT_W        = 19;
  localparam int COUNT_W          = 4;
  localparam int CITY_COUNT_RESET = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  typedef struct packed {
    logic load_wr;
    logic mirror_wr;
    logic run_init;
    logic leg_issue;
    logic compare;
    logic adv_step;
    logic emit_next;
  } ets_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic leg_last;
    logic wrap;
    logic level_zero;
  } ets_stat_t;

endpackage

/* sv/ets_ram.sv */
// ets_ram: generic single write port, single read port ram with registered read
// no dependencies
module ets_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ets_ctrl.sv */
// ets_ctrl: sequencer for load, tour scoring, permutation advance and emission
// depends on ets_pkg
module ets_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output ets_pkg::ets_cmd_t ctl,
  input  ets_pkg::ets_stat_t sts
);
  import ets_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD2, S_SCORE, S_DRAIN, S_CMP, S_ADV, S_EMIT
  } state_t;

  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_LOAD) begin
            ctl.load_wr = 1'b1;
            state_next  = S_LOAD2;
          end else begin
            ctl.run_init = 1'b1;
            state_next   = sts.count_zero ? S_IDLE : S_SCORE;
          end
        end
      end
      S_LOAD2: begin
        ctl.mirror_wr = 1'b1;
        state_next    = S_IDLE;
      end
      S_SCORE: begin
        ctl.leg_issue = 1'b1;
        if (sts.leg_last) state_next = S_DRAIN;
      end
      // last leg read returns here
      S_DRAIN: state_next = S_CMP;
      S_CMP: begin
        ctl.compare = 1'b1;
        state_next  = sts.count_one ? S_EMIT : S_ADV;
      end
      S_ADV: begin
        ctl.adv_step = 1'b1;
        if (sts.wrap && sts.level_zero) state_next = S_EMIT;
        else if (!sts.wrap)             state_next = S_SCORE;
      end
      S_EMIT: begin
        if (out_ready) begin
          ctl.emit_next = 1'b1;
          if (sts.leg_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/ets_dp.sv */
// ets_dp: distance memory, permutation registers, leg accumulator and best tour
// depends on ets_pkg, ets_ram
module ets_dp #(
  parameter int MAX_CITIES = ets_pkg::MAX_CITIES_DEF,
  parameter int DIST_BITS  = ets_pkg::DIST_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ets_pkg::COUNT_W-1:0]  cfg_wr_data,
  input  logic [ets_pkg::CITY_W-1:0]   city_a,
  input  logic [ets_pkg::CITY_W-1:0]   city_b,
  input  logic [ets_pkg::DIST_W-1:0]   pair_distance,
  input  ets_pkg::ets_cmd_t            ctl,
  output ets_pkg::ets_stat_t           sts,
  output logic [ets_pkg::CITY_W-1:0]   tour_city,
  output logic [ets_pkg::LEN_OUT_W-1:0] tour_length,
  output logic                         last_city
);
  import ets_pkg::*;

  localparam int CB    = $clog2(MAX_CITIES);
  localparam int NW    = $clog2(MAX_CITIES + 1);
  localparam int LW    = DIST_BITS + CB;
  localparam int AW    = 2 * CB;
  localparam int DEPTH = 1 << AW;

  logic [COUNT_W-1:0]   city_count;
  logic [NW-1:0]        n_eff, n;
  logic [CB-1:0]        perm [MAX_CITIES];
  logic [CB-1:0]        perm_rot [MAX_CITIES];
  logic [CB-1:0]        best_tour [MAX_CITIES];
  logic [NW-1:0]        cnt [MAX_CITIES];
  logic [CB-1:0]        level, k, k_nx;
  logic [LW-1:0]        acc, best;
  logic                 found, rd_v, improve;
  logic [CB-1:0]        ma, mb;
  logic [DIST_BITS-1:0] md;
  logic                 pair_ok;
  logic                 a_ok, b_ok;
  logic [CB-1:0]        a_idx, b_idx;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [DIST_BITS-1:0] wdata, rdata;

  assign n_eff = (city_count > COUNT_W'(MAX_CITIES)) ? NW'(MAX_CITIES) : NW'(city_count);

  assign a_ok  = (city_a >= CITY_W'(1)) && (city_a <= CITY_W'(MAX_CITIES));
  assign b_ok  = (city_b >= CITY_W'(1)) && (city_b <= CITY_W'(MAX_CITIES));
  assign a_idx = CB'(city_a - CITY_W'(1));
  assign b_idx = CB'(city_b - CITY_W'(1));

  assign we    = (ctl.load_wr && a_ok && b_ok) || (ctl.mirror_wr && pair_ok);
  assign waddr = ctl.mirror_wr ? {mb, ma} : {a_idx, b_idx};
  assign wdata = ctl.mirror_wr ? md : DIST_BITS'(pair_distance);

  // next position wraps to the start for the return leg
  assign k_nx  = (NW'(k) == n - NW'(1)) ? '0 : k + CB'(1);
  assign raddr = {perm[k], perm[k_nx]};

  ets_ram #(.WIDTH(DIST_BITS), .DEPTH(DEPTH)) u_dist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign improve = !found || (acc < best);

  assign sts.count_zero = (n_eff == '0);
  assign sts.count_one  = (n == NW'(1));
  assign sts.leg_last   = (NW'(k) == n - NW'(1));
  assign sts.wrap       = ((cnt[level] + NW'(1)) == (n - NW'(level)));
  assign sts.level_zero = (level == '0);

  // rotate the tail starting at the current level left by one
  always_comb begin
    for (int j = 0; j < MAX_CITIES; j++) begin
      perm_rot[j] = perm[j];
      if (j < MAX_CITIES - 1) begin
        if ((NW'(j) >= NW'(level)) && (NW'(j) < n - NW'(1))) perm_rot[j] = perm[j + 1];
      end
      if (NW'(j) == n - NW'(1)) perm_rot[j] = perm[level];
    end
  end

  assign tour_city   = CITY_W'(best_tour[k]) + CITY_W'(1);
  assign tour_length = LEN_OUT_W'(best);
  assign last_city   = sts.leg_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= COUNT_W'(CITY_COUNT_RESET);
      rd_v       <= 1'b0;
      found      <= 1'b0;
      n          <= '0;
      k          <= '0;
      level      <= '0;
    end else begin
      if (cfg_wr_en) city_count <= cfg_wr_data;
      rd_v <= ctl.leg_issue;

      if (ctl.load_wr) begin
        ma      <= a_idx;
        mb      <= b_idx;
        md      <= wdata;
        pair_ok <= a_ok && b_ok;
      end

      if (ctl.run_init) begin
        n     <= n_eff;
        found <= 1'b0;
        best  <= '0;
        acc   <= '0;
        k     <= '0;
        level <= (n_eff >= NW'(2)) ? CB'(n_eff - NW'(2)) : '0;
        for (int j = 0; j < MAX_CITIES; j++) begin
          perm[j] <= CB'(j);
          cnt[j]  <= '0;
        end
      end

      if (ctl.leg_issue) k <= k_nx;
      if (rd_v) acc <= acc + LW'(rdata);

      if (ctl.compare) begin
        acc <= '0;
        k   <= '0;
        if (improve) begin
          best      <= acc;
          found     <= 1'b1;
          best_tour <= perm;
        end
      end

      if (ctl.adv_step) begin
        perm <= perm_rot;
        if (sts.wrap) begin
          cnt[level] <= '0;
          if (!sts.level_zero) level <= level - CB'(1);
        end else begin
          cnt[level] <= cnt[level] + NW'(1);
          // next advance starts again at the deepest level with a choice
          level      <= CB'(n - NW'(2));
        end
      end

      if (ctl.emit_next) k <= k_nx;
    end
  end

endmodule

/* sv/exhaustive_tour_search.sv */
// exhaustive_tour_search: top level, brute force shortest closed tour search
// depends on ets_pkg, ets_ctrl, ets_dp, ets_ram
//
//   channel  handshake              payload
//   cfg      cfg_wr_en              cfg_wr_data (city_count)
//   in       in_valid / in_ready    cmd, city_a, city_b, pair_distance
//   out      out_valid / out_ready  tour_city, tour_length, last_city
//
// a load beat writes one matrix direction in IDLE and the other in LOAD2 (one ram port)
// a run beat scores every ordering of the n cities and then gives n output beats; each
// tour costs one ram read per leg, a drain state, a compare and the advance steps
// in_ready is low from a run until its last output beat is taken
// out_valid holds while out_ready is low; reset restores city_count to 2
module exhaustive_tour_search #(
  parameter int MAX_CITIES = ets_pkg::MAX_CITIES_DEF,
  parameter int DIST_BITS  = ets_pkg::DIST_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ets_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [ets_pkg::CITY_W-1:0]    city_a,
  input  logic [ets_pkg::CITY_W-1:0]    city_b,
  input  logic [ets_pkg::DIST_W-1:0]    pair_distance,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ets_pkg::CITY_W-1:0]    tour_city,
  output logic [ets_pkg::LEN_OUT_W-1:0] tour_length,
  output logic                          last_city
);
  import ets_pkg::*;

  ets_cmd_t  ctl;
  ets_stat_t sts;

  ets_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl),
    .sts       (sts)
  );

  ets_dp #(.MAX_CITIES(MAX_CITIES), .DIST_BITS(DIST_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .city_a        (city_a),
    .city_b        (city_b),
    .pair_distance (pair_distance),
    .ctl           (ctl),
    .sts           (sts),
    .tour_city     (tour_city),
    .tour_length   (tour_length),
    .last_city     (last_city)
  );

endmodule

/* dv/exhaustive_tour_search_tb.sv */
// exhaustive_tour_search_tb: self-checking bench for the brute force tour search,
// loads the distance matrix, runs searches at several city counts and checks
// every emitted city against an in-bench search; depends on ets_pkg and the rtl
module exhaustive_tour_search_tb;
  import ets_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCITY       = MAX_CITIES_DEF;
  localparam int STALL_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 64;

  typedef struct packed {
    logic [CITY_W-1:0]    city;
    logic [LEN_OUT_W-1:0] length;
    logic                 last;
  } tour_beat_t;

  logic                 clk, rst;
  logic                 cfg_wr_en;
  logic [COUNT_W-1:0]   cfg_wr_data;
  logic                 in_valid, in_ready, cmd;
  logic [CITY_W-1:0]    city_a, city_b;
  logic [DIST_W-1:0]    pair_distance;
  logic                 out_valid, out_ready, last_city;
  logic [CITY_W-1:0]    tour_city;
  logic [LEN_OUT_W-1:0] tour_length;

  // bench copy of block state
  logic [DIST_W-1:0]  dist_m [NCITY][NCITY];
  logic [COUNT_W-1:0] city_count;
  logic [2:0]         path [NCITY];
  logic [2:0]         best_path [NCITY];
  logic [19:0]        path_len, best_len;
  logic               best_found;

  tour_beat_t tour_q[$];
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1;
  int  ready_hold = 0;

  exhaustive_tour_search i_dut (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_ready, .cmd, .city_a,
    .city_b, .pair_distance, .out_valid, .out_ready, .tour_city, .tour_length,
    .last_city
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  task automatic tour_walk(input int depth, input logic [23:0] rem, input int cnt);
    logic [23:0] nxt;
    logic [2:0]  pick;
    logic [19:0] leg, total;
    int m;
    if (cnt == 0 || depth >= NCITY) return;
    for (int i = 0; i < cnt; i++) begin
      pick = rem[3*i +: 3];
      leg = (depth > 0) ? 20'(dist_m[path[depth-1]][pick]) : 20'd0;
      path[depth] = pick;
      path_len += leg;
      if (cnt == 1) begin
        total = path_len + 20'(dist_m[pick][path[0]]);
        if (!best_found || total < best_len) begin
          best_found = 1'b1;
          best_len = total;
          for (int k = 0; k <= depth; k++) best_path[k] = path[k];
        end
      end else begin
        nxt = '0;
        m = 0;
        for (int j = i + 1; j < cnt; j++) begin nxt[3*m +: 3] = rem[3*j +: 3]; m++; end
        for (int j = 0; j < i; j++) begin nxt[3*m +: 3] = rem[3*j +: 3]; m++; end
        tour_walk(depth + 1, nxt, cnt - 1);
      end
      path_len -= leg;
    end
  endtask

  task automatic predict_beat(input logic c, input logic [3:0] a, input logic [3:0] b,
                              input logic [15:0] d);
    logic [23:0] order;
    int n;
    tour_beat_t t;
    if (c == CMD_LOAD) begin
      if (a >= 1 && a <= NCITY && b >= 1 && b <= NCITY) begin
        dist_m[a-1][b-1] = d;
        dist_m[b-1][a-1] = d;
      end
      return;
    end
    n = (city_count > NCITY) ? NCITY : int'(city_count);
    for (int k = 0; k < NCITY; k++) order[3*k +: 3] = 3'(k);
    best_found = 1'b0;
    best_len = '0;
    path_len = '0;
    tour_walk(0, order, n);
    if (!best_found) return;
    for (int k = 0; k < n; k++) begin
      t.city = 4'(best_path[k]) + 4'd1;
      t.length = best_len[LEN_OUT_W-1:0];
      t.last = (k + 1 == n);
      tour_q.push_back(t);
    end
  endtask

  // one input beat; valid is only lowered when an idle cycle is taken
  task automatic send_beat(input logic c, input logic [3:0] a, input logic [3:0] b,
                           input logic [15:0] d);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    city_a <= a;
    city_b <= b;
    pair_distance <= d;
    do @(posedge clk); while (!in_ready);
    predict_beat(c, a, b, d);
  endtask

  task automatic end_stream();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    end_stream();
    while (tour_q.size() != 0) @(negedge clk);
    // a run with no tour leaves nothing to wait on, so also let it finish
    while (!in_ready) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_city_count(input logic [3:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    city_count = v;
  endtask

  // mode 0: all equal value, mode 1: random; covers cities 1 to lim
  task automatic fill_matrix(input int mode, input logic [15:0] v, input int lim);
    for (int a = 1; a <= lim; a++)
      for (int b = a; b <= lim; b++)
        send_beat(CMD_LOAD, 4'(a), 4'(b), mode ? 16'($urandom) : v);
  endtask

  task automatic test_extremes();
    fill_matrix(1, 0, NCITY);
    send_beat(CMD_LOAD, 4'd1, 4'd8, 16'hFFFF);
    send_beat(CMD_LOAD, 4'd8, 4'd2, 16'h0000);
    send_beat(CMD_LOAD, 4'd0, 4'd3, 16'h1234);
    send_beat(CMD_LOAD, 4'd9, 4'd1, 16'h5555);
    send_beat(CMD_LOAD, 4'd2, 4'd15, 16'hAAAA);
    send_beat(CMD_LOAD, 4'd1, 4'd1, 16'h0777);
    send_beat(CMD_RUN, 4'd0, 4'd0, 16'h0);
    set_city_count(4'd1);
    send_beat(CMD_RUN, 4'd15, 4'd15, 16'hFFFF);
    set_city_count(4'd0);
    send_beat(CMD_RUN, 4'd0, 4'd0, 16'h0);
    set_city_count(4'd15);
    send_beat(CMD_RUN, 4'd0, 4'd0, 16'h0);
  endtask

  task automatic test_ties();
    set_city_count(4'd4);
    fill_matrix(0, 16'd0, 4);
    send_beat(CMD_RUN, 4'd0, 4'd0, 16'h0);
    fill_matrix(0, 16'hFFFF, 5);
    set_city_count(4'd5);
    send_beat(CMD_RUN, 4'd0, 4'd0, 16'h0);
  endtask

  task automatic test_backpressure();
    set_city_count(4'd3);
    fill_matrix(1, 0, 3);
    ready_hold = 400;
    send_beat(CMD_RUN, 4'd0, 4'd0, 16'h0);
    for (int i = 0; i < 4; i++)
      send_beat(CMD_LOAD, 4'($urandom_range(1, 3)), 4'($urandom_range(1, 3)), 16'($urandom));
    send_beat(CMD_RUN, 4'd0, 4'd0, 16'h0);
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      set_city_count(4'($urandom_range(2, (p == 3) ? 7 : 6)));
      idle_on = (p != 1);
      for (int i = 0; i < 6; i++) begin
        if ($urandom_range(99) < 20)
          send_beat(CMD_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
        else if ($urandom_range(99) < 8)
          send_beat(CMD_LOAD, 4'($urandom), 4'($urandom), 16'($urandom));
        else
          send_beat(CMD_LOAD, 4'($urandom_range(1, NCITY)), 4'($urandom_range(1, NCITY)),
                    16'($urandom));
      end
      send_beat(CMD_RUN, 4'd0, 4'd0, 16'h0);
    end
    idle_on = 1;
  endtask

  // receiver: random idles plus a forced hold-off
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 6);
    end
  end

  always @(posedge clk) begin
    tour_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (tour_q.size() == 0) begin
        $display("%0t: unexpected beat city %0d length %0d last %0b",
                 $time, tour_city, tour_length, last_city);
        errors++;
      end else begin
        want = tour_q.pop_front();
        if (tour_city !== want.city) begin
          $display("%0t: tour_city expected %0d actual %0d", $time, want.city, tour_city);
          errors++;
        end
        if (tour_length !== want.length) begin
          $display("%0t: tour_length expected %0d actual %0d", $time, want.length,
                   tour_length);
          errors++;
        end
        if (last_city !== want.last) begin
          $display("%0t: last_city expected %0b actual %0b", $time, want.last, last_city);
          errors++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("exhaustive_tour_search_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    cmd = CMD_LOAD;
    city_a = '0;
    city_b = '0;
    pair_distance = '0;
    out_ready = 1'b0;
    city_count = 4'(CITY_COUNT_RESET);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_ties();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0 && tour_q.size() == 0)
      $display("exhaustive_tour_search_tb OK");
    else
      $display("exhaustive_tour_search_tb NOT OK");
    $finish;
  end
endmodule
